[src/audio_playback_fifo_defines.svh]
// ----------------------------------------------------------------------------
// audio_playback_fifo_defines
// assertion macros used by the playback fifo top level
// ----------------------------------------------------------------------------
`ifndef AUDIO_PLAYBACK_FIFO_DEFINES_SVH
`define AUDIO_PLAYBACK_FIFO_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define APF_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// condition holds at every clock edge out of reset
`define APF_ASSERT_HOLDS(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
    else $error(msg);

`endif

[src/apf_pkg.sv]
// ----------------------------------------------------------------------------
// apf_pkg
// widths, codes and controller types of the audio playback fifo
// ----------------------------------------------------------------------------
package apf_pkg;

  // payload field widths
  localparam int OP_W       = 2;
  localparam int FRAMES_W   = 15;
  localparam int PTS_IN_W   = 32;
  localparam int TB_W       = 32;
  localparam int SAMPLE_W   = 16;
  localparam int PTS_W      = 64;
  localparam int CH_W       = 2;
  localparam int RATE_W     = 18;
  localparam int PROD_W     = PTS_IN_W + RATE_W;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 18;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 2'd1;
  localparam logic [CH_W-1:0]      CHANNELS_RESET    = 2'd2;
  localparam logic [RATE_W-1:0]    SAMPLE_RATE_RESET = 18'd48000;

  // defaults of the top level parameters
  localparam int DEF_BUFFER_DEPTH    = 16384;
  localparam int DEF_MAX_READ_FRAMES = 32;

  // operation codes
  localparam logic [OP_W-1:0] OP_HEADER = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV_GO,
    ST_DIV,
    ST_HEADER,
    ST_RD_SETUP,
    ST_RD_FETCH,
    ST_RD_EMIT
  } apf_state_e;

  typedef struct packed {
    logic in_ready;
    logic mul_load;
    logic div_start;
    logic pts_load;
    logic hdr_emit;
    logic rd_setup;
    logic rd_fetch;
    logic rd_emit;
  } apf_cmd_t;

  typedef struct packed {
    logic            in_valid;
    logic [OP_W-1:0] in_op;
    logic            hdr_load;
    logic            rd_none;
    logic            div_done;
    logic            out_free;
    logic            rd_last;
  } apf_stat_t;

endpackage

[src/apf_in_if.sv]
// ----------------------------------------------------------------------------
// apf_in_if
// input channel: header, sample write and read request items
// ----------------------------------------------------------------------------
interface apf_in_if;
  import apf_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [OP_W-1:0]            op;
  logic [FRAMES_W-1:0]        frame_count;
  logic [PTS_IN_W-1:0]        packet_pts;
  logic [TB_W-1:0]            timebase;
  logic                       planar;
  logic signed [SAMPLE_W-1:0] sample_in;

  modport source (
    output valid, op, frame_count, packet_pts, timebase, planar, sample_in,
    input  ready
  );

  modport sink (
    input  valid, op, frame_count, packet_pts, timebase, planar, sample_in,
    output ready
  );

endinterface

[src/apf_out_if.sv]
// ----------------------------------------------------------------------------
// apf_out_if
// output channel: header answers and read samples
// ----------------------------------------------------------------------------
interface apf_out_if;
  import apf_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic                       accepted;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic                       underrun;
  logic                       last;
  logic [PTS_W-1:0]           pts_now;

  modport source (
    output valid, kind, accepted, sample_out, underrun, last, pts_now,
    input  ready
  );

  modport sink (
    input  valid, kind, accepted, sample_out, underrun, last, pts_now,
    output ready
  );

endinterface

[src/audio_playback_fifo.sv]
// ----------------------------------------------------------------------------
// audio_playback_fifo
// pcm playback ring buffer with packet admission and zero-filled reads
// ----------------------------------------------------------------------------
//
// channel   dir  handshake      payload
// -------   ---  ---------      -------
// in_i      in   valid/ready    op, frame_count, packet_pts, timebase,
//                               planar, sample_in
// out_o     out  valid/ready    kind, accepted, sample_out, underrun,
//                               last, pts_now
// cfg       in   cfg_we_i only  cfg_idx_i, cfg_data_i
//
// a sample write is taken in the idle state; a header is answered directly,
// or after a multiply and the divider, which makes one quotient bit a cycle
// over the 50-bit product, when it loads the timestamp
// a read passes an accept and a setup state, then a fetch and an emit state
// per sample, as the registered store read precedes each output load
// reset clears pointers, counters and control; the store needs no clearing
// pass, since the fill level keeps reads on written entries only
// a stall on out_o holds the sequencer in its header or emit state; the
// next item is taken while the last result waits in the output register
//
`include "audio_playback_fifo_defines.svh"

module audio_playback_fifo #(
  parameter int BUFFER_DEPTH    = apf_pkg::DEF_BUFFER_DEPTH,
  parameter int MAX_READ_FRAMES = apf_pkg::DEF_MAX_READ_FRAMES
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [apf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [apf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  apf_in_if.sink                         in_i,
  apf_out_if.source                      out_o
);
  import apf_pkg::*;

  localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);

  // command and status between sequencer and datapath
  apf_cmd_t         cmd;
  apf_stat_t        stat;

  // occupancy taps for the checks below
  logic [CNT_W-1:0] dp_fill;
  logic [CNT_W-1:0] dp_pending;

  // sequencer: idle, timestamp load, header answer, read streaming
  apf_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  // store, pointers, counter, divider and output register
  apf_datapath #(
    .BUFFER_DEPTH    (BUFFER_DEPTH),
    .MAX_READ_FRAMES (MAX_READ_FRAMES)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_i),
    .out_o      (out_o),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .fill_o     (dp_fill),
    .pending_o  (dp_pending)
  );

  // zero-filled samples only on reads, and really zero
  `APF_ASSERT_IMPLY(a_underrun_zero, clk_i, rst_ni, out_o.valid && out_o.underrun, out_o.kind && (out_o.sample_out == '0), "underrun sample not a zero read sample")

  // a header answer is a single result without sample data
  `APF_ASSERT_IMPLY(a_header_single, clk_i, rst_ni, out_o.valid && !out_o.kind, out_o.last && !out_o.underrun, "header answer malformed")

  // an admitted packet always fits beside what is already stored
  `APF_ASSERT_HOLDS(a_room_kept, clk_i, rst_ni, ({1'b0, dp_fill} + {1'b0, dp_pending}) <= (CNT_W+1)'(BUFFER_DEPTH), "pending packet exceeds free space")

endmodule

[src/apf_div.sv]
// ----------------------------------------------------------------------------
// apf_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module apf_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [apf_pkg::PROD_W-1:0]   dividend_i,
  input  logic [apf_pkg::TB_W-1:0]     divisor_i,
  output logic                         done_o,
  output logic [apf_pkg::PROD_W-1:0]   quotient_o
);
  import apf_pkg::*;

  localparam int CNT_W = $clog2(PROD_W);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [TB_W-1:0]   rem_q, rem_d;
  logic [PROD_W-1:0] quo_q, quo_d;
  logic [TB_W-1:0]   dvs_q, dvs_d;
  logic [TB_W:0]     trial;
  logic              fits;

  // shift next dividend bit into the partial remainder
  assign trial = {rem_q, quo_q[PROD_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? TB_W'(trial - {1'b0, dvs_q}) : TB_W'(trial);
      quo_d = {quo_q[PROD_W-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(PROD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

[src/apf_ctrl.sv]
// ----------------------------------------------------------------------------
// apf_ctrl
// sequencer for header, timestamp load and read streaming
// ----------------------------------------------------------------------------
module apf_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  apf_pkg::apf_stat_t stat_i,
  output apf_pkg::apf_cmd_t  cmd_o
);
  import apf_pkg::*;

  apf_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (stat_i.in_valid) begin
          case (stat_i.in_op)
            OP_HEADER: state_d = stat_i.hdr_load ? ST_MUL : ST_HEADER;
            OP_READ:   state_d = stat_i.rd_none ? ST_IDLE : ST_RD_SETUP;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_MUL:      state_d = ST_DIV_GO;
      ST_DIV_GO:   state_d = ST_DIV;
      ST_DIV:      if (stat_i.div_done) state_d = ST_HEADER;
      ST_HEADER:   if (stat_i.out_free) state_d = ST_IDLE;
      ST_RD_SETUP: state_d = ST_RD_FETCH;
      ST_RD_FETCH: state_d = ST_RD_EMIT;
      ST_RD_EMIT: begin
        if (stat_i.out_free) state_d = stat_i.rd_last ? ST_IDLE : ST_RD_FETCH;
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE:     cmd_o.in_ready  = 1'b1;
      ST_MUL:      cmd_o.mul_load  = 1'b1;
      ST_DIV_GO:   cmd_o.div_start = 1'b1;
      ST_DIV:      cmd_o.pts_load  = stat_i.div_done;
      ST_HEADER:   cmd_o.hdr_emit  = stat_i.out_free;
      ST_RD_SETUP: cmd_o.rd_setup  = 1'b1;
      ST_RD_FETCH: cmd_o.rd_fetch  = 1'b1;
      ST_RD_EMIT:  cmd_o.rd_emit   = stat_i.out_free;
      default:     cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[src/apf_datapath.sv]
// ----------------------------------------------------------------------------
// apf_datapath
// sample store, pointers, timestamp counter and output register
// ----------------------------------------------------------------------------
module apf_datapath #(
  parameter int BUFFER_DEPTH    = apf_pkg::DEF_BUFFER_DEPTH,
  parameter int MAX_READ_FRAMES = apf_pkg::DEF_MAX_READ_FRAMES
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [apf_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [apf_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  apf_in_if.sink                            in_i,
  apf_out_if.source                         out_o,
  input  apf_pkg::apf_cmd_t                 cmd_i,
  output apf_pkg::apf_stat_t                stat_o,
  output logic [$clog2(BUFFER_DEPTH+1)-1:0] fill_o,
  output logic [$clog2(BUFFER_DEPTH+1)-1:0] pending_o
);
  import apf_pkg::*;

  localparam int SPAN  = 2 * BUFFER_DEPTH;
  localparam int PTR_W = $clog2(SPAN);
  localparam int AW    = $clog2(BUFFER_DEPTH);
  localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
  localparam int NF_W  = $clog2(MAX_READ_FRAMES + 1);
  localparam int TOT_W = $clog2(2 * MAX_READ_FRAMES + 1);
  localparam int CMP_W = (CNT_W > FRAMES_W) ? CNT_W : FRAMES_W;
  localparam int DW    = (CNT_W > TOT_W) ? CNT_W : TOT_W;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(SPAN - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [AW-1:0] ptr_addr(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] a;
    a = (p >= PTR_W'(BUFFER_DEPTH)) ? p - PTR_W'(BUFFER_DEPTH) : p;
    return a[AW-1:0];
  endfunction

  // configuration
  logic [CH_W-1:0]   channels_q;
  logic [RATE_W-1:0] rate_q;
  logic              stereo;

  // control state
  logic [PTR_W-1:0]  wp_q, rp_q;
  logic [CNT_W-1:0]  pending_q;
  logic [PTS_W-1:0]  pts_q;
  logic [TOT_W-1:0]  rd_total_q, rd_deliv_q, rd_idx_q;
  logic              out_valid_q;

  // payload state
  logic [FRAMES_W-1:0]  frames_q;
  logic [PTS_IN_W-1:0]  ppts_q;
  logic [TB_W-1:0]      tb_q;
  logic                 planar_q;
  logic [PROD_W-1:0]    prod_q;
  logic                 und_q;
  logic [SAMPLE_W-1:0]  rdata_q;
  logic                 out_kind_q, out_acc_q, out_und_q, out_last_q;
  logic [SAMPLE_W-1:0]  out_smp_q;
  logic [PTS_W-1:0]     out_pts_q;

  logic [SAMPLE_W-1:0]  mem [BUFFER_DEPTH];

  logic                 accept, wr_en, out_load, rd_take;
  logic [PTR_W:0]       fill_wide;
  logic [CNT_W-1:0]     fill, free, free_frames;
  logic                 hdr_ok;
  logic [FRAMES_W:0]    hdr_samples;
  logic [NF_W-1:0]      rd_frames;
  logic [TOT_W-1:0]     rd_total, rd_deliv, pts_adv;
  logic [PROD_W-1:0]    quotient;
  logic                 div_done;

  assign stereo   = channels_q[1];
  assign accept   = in_i.valid && cmd_i.in_ready;
  assign wr_en    = accept && (in_i.op == OP_WRITE) && (pending_q != '0);
  assign out_load = cmd_i.hdr_emit || cmd_i.rd_emit;
  assign rd_take  = rd_idx_q < rd_deliv_q;

  assign in_i.ready = cmd_i.in_ready;

  // fill level over pointers that run modulo twice the depth
  assign fill_wide = (wp_q >= rp_q) ? {1'b0, wp_q} - {1'b0, rp_q}
                                    : {1'b0, wp_q} + (PTR_W+1)'(SPAN) - {1'b0, rp_q};
  assign fill        = CNT_W'(fill_wide);
  assign free        = CNT_W'(BUFFER_DEPTH) - fill;
  assign free_frames = stereo ? (free >> 1) : free;
  assign hdr_ok      = (CMP_W'(frames_q) <= CMP_W'(free_frames)) && !planar_q;
  assign hdr_samples = stereo ? {frames_q, 1'b0} : {1'b0, frames_q};

  // read request: saturate, expand to samples, clip to what is stored
  assign rd_frames = (frames_q > FRAMES_W'(MAX_READ_FRAMES)) ? NF_W'(MAX_READ_FRAMES)
                                                              : NF_W'(frames_q);
  assign rd_total  = stereo ? TOT_W'({rd_frames, 1'b0}) : TOT_W'(rd_frames);
  assign rd_deliv  = (DW'(fill) >= DW'(rd_total)) ? rd_total : TOT_W'(fill);
  assign pts_adv   = stereo ? (rd_deliv >> 1) : rd_deliv;

  apf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (prod_q),
    .divisor_i  (tb_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      channels_q  <= CHANNELS_RESET;
      rate_q      <= SAMPLE_RATE_RESET;
      wp_q        <= '0;
      rp_q        <= '0;
      pending_q   <= '0;
      pts_q       <= '0;
      rd_total_q  <= '0;
      rd_deliv_q  <= '0;
      rd_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_CHANNELS:    channels_q <= cfg_data_i[CH_W-1:0];
          CFG_SAMPLE_RATE: rate_q     <= cfg_data_i[RATE_W-1:0];
          default:         ;
        endcase
      end
      if (wr_en) begin
        wp_q      <= ptr_next(wp_q);
        pending_q <= pending_q - 1'b1;
      end
      if (cmd_i.hdr_emit) begin
        pending_q <= hdr_ok ? CNT_W'(hdr_samples) : '0;
      end
      if (cmd_i.pts_load) begin
        pts_q <= PTS_W'(quotient);
      end
      if (cmd_i.rd_setup) begin
        rd_total_q <= rd_total;
        rd_deliv_q <= rd_deliv;
        rd_idx_q   <= '0;
        pts_q      <= pts_q + PTS_W'(pts_adv);
      end
      if (cmd_i.rd_fetch && rd_take) begin
        rp_q <= ptr_next(rp_q);
      end
      if (cmd_i.rd_emit) begin
        rd_idx_q <= rd_idx_q + 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      frames_q <= in_i.frame_count;
      ppts_q   <= in_i.packet_pts;
      tb_q     <= in_i.timebase;
      planar_q <= in_i.planar;
    end
    if (cmd_i.mul_load) begin
      prod_q <= ppts_q * rate_q;
    end
    if (cmd_i.rd_fetch) begin
      und_q <= !rd_take;
    end
    if (cmd_i.hdr_emit) begin
      out_kind_q <= 1'b0;
      out_acc_q  <= hdr_ok;
      out_smp_q  <= '0;
      out_und_q  <= 1'b0;
      out_last_q <= 1'b1;
      out_pts_q  <= pts_q;
    end else if (cmd_i.rd_emit) begin
      out_kind_q <= 1'b1;
      out_acc_q  <= 1'b0;
      out_smp_q  <= und_q ? '0 : rdata_q;
      out_und_q  <= und_q;
      out_last_q <= stat_o.rd_last;
      out_pts_q  <= pts_q;
    end
  end

  // sample store
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[ptr_addr(wp_q)] <= in_i.sample_in;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_fetch) begin
      rdata_q <= mem[ptr_addr(rp_q)];
    end
  end

  always_comb begin
    stat_o          = '0;
    stat_o.in_valid = in_i.valid;
    stat_o.in_op    = in_i.op;
    stat_o.hdr_load = (pts_q == '0) && (in_i.timebase != '0);
    stat_o.rd_none  = (in_i.frame_count == '0);
    stat_o.div_done = div_done;
    stat_o.out_free = !out_valid_q || out_o.ready;
    stat_o.rd_last  = (rd_idx_q == rd_total_q - 1'b1);
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.kind       = out_kind_q;
  assign out_o.accepted   = out_acc_q;
  assign out_o.sample_out = out_smp_q;
  assign out_o.underrun   = out_und_q;
  assign out_o.last       = out_last_q;
  assign out_o.pts_now    = out_pts_q;

  assign fill_o    = fill;
  assign pending_o = pending_q;

endmodule
